// File: design/ppba_pkg.sv
// shared types, constants and helper functions of the page bitmap allocator
package ppba_pkg;

	localparam int WORD_BITS = 64;
	localparam int MAP_WORDS = 256;
	localparam int ADDR_W = 8;
	localparam int BIT_W = 6;
	localparam int PAGE_W = 14;
	localparam int PAGE_LIMIT = 16384;
	localparam int GROUP = 16;
	localparam int GRP_W = 4;

	localparam int DEF_NUM_TABLES = 32;
	localparam int DEF_PAGES_PER_TABLE = 512;
	localparam int DEF_RESERVED_TABLES = 24;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_CLAIM   = 2'd1,
		OP_RELEASE = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_USED   = 2'd1,
		ST_NOFREE = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [PAGE_W-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] result_page;
		logic              was_used;
		status_t           status;
	} rsp_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SCAN,
		CS_READ,
		CS_LOAD,
		CS_UPDATE,
		CS_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load_req;
		logic scan_step;
		logic rd_en;
		logic load_word;
		logic update;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic scan_found;
		logic scan_last;
		logic out_busy;
	} dp_status_t;

	function automatic int total_pages(int nt, int ppt);
		int n;
		n = nt * ppt;
		return (n > PAGE_LIMIT) ? PAGE_LIMIT : n;
	endfunction

	function automatic int reserved_pages(int rt, int ppt, int total);
		int n;
		n = rt * ppt;
		return (n > total) ? total : n;
	endfunction

	// n low bits set, n in 0..64
	function automatic logic [WORD_BITS-1:0] low_ones(int n);
		if (n >= WORD_BITS) begin
			return '1;
		end
		return (64'd1 << n) - 64'd1;
	endfunction

	// word contents after reset: pages below the reserved count are used
	function automatic logic [WORD_BITS-1:0] reset_word(logic [ADDR_W-1:0] w, int rsv);
		int base;
		base = int'(w) * WORD_BITS;
		if (rsv <= base) begin
			return '0;
		end
		return low_ones(rsv - base);
	endfunction

	// bits of pages at or above the managed count
	function automatic logic [WORD_BITS-1:0] beyond_mask(logic [ADDR_W-1:0] w, int total);
		int base;
		base = int'(w) * WORD_BITS;
		if (total <= base) begin
			return '1;
		end
		return ~low_ones(total - base);
	endfunction

	function automatic logic [BIT_W-1:0] first_zero64(logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!v[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [GRP_W-1:0] first_zero16(logic [GROUP-1:0] v);
		logic [GRP_W-1:0] idx;
		idx = '0;
		for (int i = GROUP - 1; i >= 0; i--) begin
			if (!v[i]) begin
				idx = GRP_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// File: design/ppba_ctrl.sv
// controller state machine of the page bitmap allocator
module ppba_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  ppba_pkg::dp_status_t  status,
	output ppba_pkg::dp_cmd_t     cmd
);

	ppba_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppba_pkg::CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ppba_pkg::CS_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d = status.is_alloc ? ppba_pkg::CS_SCAN : ppba_pkg::CS_READ;
				end
			end
			ppba_pkg::CS_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_found) begin
					state_d = ppba_pkg::CS_READ;
				end else if (status.scan_last) begin
					state_d = ppba_pkg::CS_DONE;
				end
			end
			ppba_pkg::CS_READ: begin
				cmd.rd_en = 1'b1;
				state_d = ppba_pkg::CS_LOAD;
			end
			ppba_pkg::CS_LOAD: begin
				cmd.load_word = 1'b1;
				state_d = ppba_pkg::CS_UPDATE;
			end
			ppba_pkg::CS_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ppba_pkg::CS_DONE;
			end
			ppba_pkg::CS_DONE: begin
				if (!status.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ppba_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = ppba_pkg::CS_IDLE;
			end
		endcase
	end

endmodule

// File: design/ppba_datapath.sv
// bitmap store, full-word summary, search and result registers
module ppba_datapath #(
	parameter int NUM_TABLES      = ppba_pkg::DEF_NUM_TABLES,
	parameter int PAGES_PER_TABLE = ppba_pkg::DEF_PAGES_PER_TABLE,
	parameter int RESERVED_TABLES = ppba_pkg::DEF_RESERVED_TABLES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ppba_pkg::req_t        req,
	output ppba_pkg::rsp_t        rsp,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	input  ppba_pkg::dp_cmd_t     cmd,
	output ppba_pkg::dp_status_t  status
);

	localparam int TOTAL = ppba_pkg::total_pages(NUM_TABLES, PAGES_PER_TABLE);
	localparam int RSV = ppba_pkg::reserved_pages(RESERVED_TABLES, PAGES_PER_TABLE, TOTAL);
	localparam int WB = ppba_pkg::WORD_BITS;
	localparam int AW = ppba_pkg::ADDR_W;
	localparam int BW = ppba_pkg::BIT_W;
	localparam int PW = ppba_pkg::PAGE_W;

	logic [WB-1:0] mem [ppba_pkg::MAP_WORDS];
	logic [ppba_pkg::MAP_WORDS-1:0] valid_q;
	logic [ppba_pkg::MAP_WORDS-1:0] full_q;

	ppba_pkg::op_t                op_q;
	logic [PW-1:0]                page_q;
	logic [AW-1:0]                addr_q;
	logic [ppba_pkg::GRP_W-1:0]   grp_q;
	logic [WB-1:0]                rd_word_q;
	logic                         rd_valid_q;
	logic [WB-1:0]                word_q;
	logic [BW-1:0]                bit_q;
	ppba_pkg::rsp_t               res_q;
	ppba_pkg::rsp_t               out_q;
	logic                         out_valid_q;

	logic [ppba_pkg::GROUP-1:0]   grp_full;
	logic [ppba_pkg::GRP_W-1:0]   scan_idx;
	logic                         scan_found;
	logic [WB-1:0]                cur_word;
	logic [WB-1:0]                eff_word;
	logic                         is_alloc;
	logic                         in_map;
	logic                         prev;
	logic                         wr_en;
	logic [WB-1:0]                new_word;
	logic                         new_full;
	ppba_pkg::status_t            res_status;

	// summary scan, sixteen words a step
	assign grp_full   = full_q[grp_q * ppba_pkg::GROUP +: ppba_pkg::GROUP];
	assign scan_found = (grp_full != '1);
	assign scan_idx   = ppba_pkg::first_zero16(grp_full);

	assign status.is_alloc   = (req.op == ppba_pkg::OP_ALLOC);
	assign status.scan_found = scan_found;
	assign status.scan_last  = (grp_q == '1);
	assign status.out_busy   = out_valid_q && !rsp_ready;

	// never-written words read as their reset contents
	assign cur_word = rd_valid_q ? rd_word_q : ppba_pkg::reset_word(addr_q, RSV);
	assign eff_word = cur_word | ppba_pkg::beyond_mask(addr_q, TOTAL);

	assign is_alloc = (op_q == ppba_pkg::OP_ALLOC);
	assign in_map   = is_alloc || (int'(page_q) < TOTAL);
	assign prev     = in_map ? word_q[bit_q] : 1'b1;

	always_comb begin
		wr_en = 1'b0;
		new_word = word_q;
		res_status = ppba_pkg::ST_OK;
		unique case (op_q)
			ppba_pkg::OP_ALLOC: begin
				wr_en = 1'b1;
				new_word[bit_q] = 1'b1;
			end
			ppba_pkg::OP_CLAIM: begin
				if (prev) begin
					res_status = ppba_pkg::ST_USED;
				end else begin
					wr_en = 1'b1;
					new_word[bit_q] = 1'b1;
				end
			end
			ppba_pkg::OP_RELEASE: begin
				wr_en = in_map;
				new_word[bit_q] = 1'b0;
			end
			ppba_pkg::OP_QUERY: begin
				wr_en = 1'b0;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign new_full = ((new_word | ppba_pkg::beyond_mask(addr_q, TOTAL)) == '1);

	// bitmap memory, one port used per cycle
	always_ff @(posedge clk) begin
		if (cmd.update && wr_en) begin
			mem[addr_q] <= new_word;
		end
		if (cmd.rd_en) begin
			rd_word_q  <= mem[addr_q];
			rd_valid_q <= valid_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int w = 0; w < ppba_pkg::MAP_WORDS; w++) begin
				full_q[w] <= ((ppba_pkg::reset_word(AW'(w), RSV)
					| ppba_pkg::beyond_mask(AW'(w), TOTAL)) == '1);
			end
			grp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update && wr_en) begin
				valid_q[addr_q] <= 1'b1;
				full_q[addr_q]  <= new_full;
			end
			if (cmd.load_req) begin
				grp_q <= '0;
			end else if (cmd.scan_step && !scan_found) begin
				grp_q <= grp_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			op_q   <= req.op;
			page_q <= req.page_number;
			addr_q <= req.page_number[PW-1:BW];
		end
		if (cmd.scan_step) begin
			if (scan_found) begin
				addr_q <= {grp_q, scan_idx};
			end else if (grp_q == '1) begin
				res_q.result_page <= '0;
				res_q.was_used    <= 1'b0;
				res_q.status      <= ppba_pkg::ST_NOFREE;
			end
		end
		if (cmd.load_word) begin
			word_q <= cur_word;
			bit_q  <= is_alloc ? ppba_pkg::first_zero64(eff_word) : page_q[BW-1:0];
		end
		if (cmd.update) begin
			res_q.result_page <= is_alloc ? {addr_q, bit_q} : page_q;
			res_q.was_used    <= prev;
			res_q.status      <= res_status;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

endmodule

// File: design/physical_page_bitmap_allocator.sv
// top level of the physical page bitmap allocator
//
// one bit per physical page frame, 64 pages to a stored word, 256 words
// request channel (req_valid/req_ready, req): op and page_number
//   allocate takes the lowest free page, claim sets a named page unless it is used,
//   release clears one page bit, query reads it
// response channel (rsp_valid/rsp_ready, rsp): result_page, was_used, status
// one item in, one item out, strictly in order, one request in flight at a time
// claim, release and query go from acceptance through the read, load, update and done
//   states; done hands the result to the output register
// allocate: a per-word "full" summary is scanned sixteen words a cycle (up to 16 steps),
//   then one memory read, one bit search, one write
// the request rate is set by the single-port bitmap memory read-modify-write and the
//   summary scan
// reset: the map is ready at once, no clearing pass; per-word valid bits make
//   unwritten words read as their reset contents (reserved tables used)
// a stalled receiver holds the response in the output register; the next item
//   is still accepted and worked on, and waits at its end for that register
module physical_page_bitmap_allocator #(
	parameter int NUM_TABLES      = ppba_pkg::DEF_NUM_TABLES,
	parameter int PAGES_PER_TABLE = ppba_pkg::DEF_PAGES_PER_TABLE,
	parameter int RESERVED_TABLES = ppba_pkg::DEF_RESERVED_TABLES
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ppba_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ppba_pkg::rsp_t  rsp
);

	// command and status between sequencer and datapath
	ppba_pkg::dp_cmd_t    cmd;
	ppba_pkg::dp_status_t dp_status;

	ppba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (dp_status),
		.cmd       (cmd)
	);

	ppba_datapath #(
		.NUM_TABLES      (NUM_TABLES),
		.PAGES_PER_TABLE (PAGES_PER_TABLE),
		.RESERVED_TABLES (RESERVED_TABLES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.status    (dp_status)
	);

	// only one request in flight: an accepted item closes the request side
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	// a finished result always reaches the output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> rsp_valid)
		else $error("result loaded but response not valid");

	// a failed allocation reports page zero with the used flag clear
	a_nofree_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ppba_pkg::ST_NOFREE |-> rsp.result_page == '0 && !rsp.was_used)
		else $error("no-free response with wrong fields");

	// a refused claim reports the page as used
	a_used_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ppba_pkg::ST_USED |-> rsp.was_used)
		else $error("refused claim without used flag");

endmodule
